/* hdl/iso_duration_parser_top_macros.svh */
// Assertion macros for the duration parser.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef ISO_DURATION_PARSER_TOP_MACROS_SVH
`define ISO_DURATION_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IDP_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("idp same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IDP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idp next-cycle check failed");

`endif

/* hdl/idp_pkg.sv */
// Shared types and constants for the duration parser.
// No dependencies.
`default_nettype none

package idp_pkg;

	localparam int NUM_FIELDS = 7;

	// ASCII codes
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	// count slots
	localparam logic [2:0] SLOT_YEARS  = 3'd0;
	localparam logic [2:0] SLOT_MONTHS = 3'd1;
	localparam logic [2:0] SLOT_WEEKS  = 3'd2;
	localparam logic [2:0] SLOT_DAYS   = 3'd3;
	localparam logic [2:0] SLOT_HOURS  = 3'd4;
	localparam logic [2:0] SLOT_MINS   = 3'd5;
	localparam logic [2:0] SLOT_SECS   = 3'd6;

	// minutes per unit
	localparam logic [31:0] MIN_PER_HOUR  = 32'd60;
	localparam logic [31:0] MIN_PER_DAY   = 32'd1440;
	localparam logic [31:0] MIN_PER_WEEK  = 32'd10080;
	localparam logic [31:0] MIN_PER_MONTH = 32'd43800;
	localparam logic [31:0] MIN_PER_YEAR  = 32'd525960;

	typedef enum logic [9:0] {
		PH_EXPECT_P  = 10'b00_0000_0001,
		PH_DATE_Y    = 10'b00_0000_0010,
		PH_DATE_M    = 10'b00_0000_0100,
		PH_DATE_W    = 10'b00_0000_1000,
		PH_DATE_D    = 10'b00_0001_0000,
		PH_DATE_DONE = 10'b00_0010_0000,
		PH_TIME_H    = 10'b00_0100_0000,
		PH_TIME_M    = 10'b00_1000_0000,
		PH_TIME_S    = 10'b01_0000_0000,
		PH_ALL_DONE  = 10'b10_0000_0000
	} idp_phase_t;

	// one parsed string: low 32 bits of each count plus the overflow flag
	typedef struct packed {
		logic [NUM_FIELDS-1:0][31:0] cnt;
		logic                        overflow;
	} idp_result_t;

endpackage

`default_nettype wire

/* hdl/idp_parser.sv */
// Per-character grammar tracker, digit accumulator and count registers.
// Depends on idp_pkg and iso_duration_parser_top_macros.svh.
`default_nettype none
`include "iso_duration_parser_top_macros.svh"

module idp_parser import idp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	output idp_result_t      result
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	idp_phase_t                            phase_q, phase_d, acc_phase;
	logic                                  stopped_q, stopped_d;
	logic [COUNT_WIDTH-1:0]                acc_q, acc_d, acc_x10;
	logic                                  have_q, have_d;
	logic                                  accovf_q, accovf_d;
	logic [NUM_FIELDS-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                                  ovf_q, ovf_d;
	logic [9:0][COUNT_WIDTH-1:0]           lim;
	logic                                  is_digit, in_date, in_time, halt, do_acc;
	logic [3:0]                            dig;
	logic [2:0]                            slot;

	// largest accumulator value that can still take digit g without saturating
	for (genvar g = 0; g < 10; g++) begin : g_lim
		localparam logic [COUNT_WIDTH-1:0] LIM = (CNT_MAX - COUNT_WIDTH'(g)) / 10;
		assign lim[g] = LIM;
	end

	assign is_digit = char_code inside {[CH_0:CH_9]};
	assign dig      = 4'(char_code - CH_0);
	assign in_date  = phase_q inside {PH_DATE_Y, PH_DATE_M, PH_DATE_W, PH_DATE_D};
	assign in_time  = phase_q inside {PH_TIME_H, PH_TIME_M, PH_TIME_S};
	assign acc_x10  = (acc_q << 3) + (acc_q << 1);

	always_comb begin
		phase_d   = phase_q;
		stopped_d = stopped_q;
		acc_d     = acc_q;
		have_d    = have_q;
		accovf_d  = accovf_q;
		cnt_d     = cnt_q;
		ovf_d     = ovf_q;
		halt      = 1'b0;
		do_acc    = 1'b0;
		slot      = SLOT_YEARS;
		acc_phase = phase_q;

		if (!stopped_q) begin
			if (phase_q == PH_EXPECT_P) begin
				if (char_code == CH_P) begin
					phase_d = PH_DATE_Y;
				end else begin
					halt = 1'b1;
				end
			end else if (is_digit) begin
				if (in_date || in_time) begin
					if (acc_q > lim[dig]) begin
						acc_d    = CNT_MAX;
						accovf_d = 1'b1;
					end else begin
						acc_d = acc_x10 + COUNT_WIDTH'(dig);
					end
					have_d = 1'b1;
				end else begin
					halt = 1'b1;
				end
			end else if (char_code == CH_T) begin
				if (!have_q && (in_date || phase_q == PH_DATE_DONE)) begin
					phase_d = PH_TIME_H;
				end else begin
					halt = 1'b1;
				end
			end else if (!have_q) begin
				halt = 1'b1;
			end else if (in_date) begin
				case (char_code)
					CH_Y: begin
						do_acc = (phase_q == PH_DATE_Y);
						slot = SLOT_YEARS; acc_phase = PH_DATE_M;
					end
					CH_M: begin
						do_acc = phase_q inside {PH_DATE_Y, PH_DATE_M};
						slot = SLOT_MONTHS; acc_phase = PH_DATE_W;
					end
					CH_W: begin
						do_acc = phase_q inside {PH_DATE_Y, PH_DATE_M, PH_DATE_W};
						slot = SLOT_WEEKS; acc_phase = PH_DATE_D;
					end
					CH_D: begin
						do_acc = 1'b1;
						slot = SLOT_DAYS; acc_phase = PH_DATE_DONE;
					end
					default: do_acc = 1'b0;
				endcase
				halt = !do_acc;
			end else if (in_time) begin
				case (char_code)
					CH_H: begin
						do_acc = (phase_q == PH_TIME_H);
						slot = SLOT_HOURS; acc_phase = PH_TIME_M;
					end
					CH_M: begin
						do_acc = phase_q inside {PH_TIME_H, PH_TIME_M};
						slot = SLOT_MINS; acc_phase = PH_TIME_S;
					end
					CH_S: begin
						do_acc = 1'b1;
						slot = SLOT_SECS; acc_phase = PH_ALL_DONE;
					end
					default: do_acc = 1'b0;
				endcase
				halt = !do_acc;
			end else begin
				halt = 1'b1;
			end
		end

		if (halt) begin
			stopped_d = 1'b1;
			acc_d     = '0;
			have_d    = 1'b0;
			accovf_d  = 1'b0;
		end
		if (do_acc) begin
			cnt_d[slot] = acc_q;
			ovf_d       = ovf_q | accovf_q;
			acc_d       = '0;
			have_d      = 1'b0;
			accovf_d    = 1'b0;
			phase_d     = acc_phase;
		end
	end

	// result reflects the state after the current character
	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			result.cnt[i] = 32'(cnt_d[i]);
		end
		result.overflow = ovf_d;
	end

	// last character restarts the parse for the next string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_EXPECT_P;
			stopped_q <= 1'b0;
			acc_q     <= '0;
			have_q    <= 1'b0;
			accovf_q  <= 1'b0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				phase_q   <= PH_EXPECT_P;
				stopped_q <= 1'b0;
				acc_q     <= '0;
				have_q    <= 1'b0;
				accovf_q  <= 1'b0;
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				stopped_q <= stopped_d;
				acc_q     <= acc_d;
				have_q    <= have_d;
				accovf_q  <= accovf_d;
				cnt_q     <= cnt_d;
				ovf_q     <= ovf_d;
			end
		end
	end

	`IDP_ASSERT_NEXT(a_stop_holds, stopped_q && !(take && last_char), stopped_q)
	`IDP_ASSERT_NEXT(a_stop_freezes, stopped_q && take && !last_char, $stable(cnt_q) && $stable(ovf_q))
	`IDP_ASSERT_SAME(a_idle_clean, phase_q == PH_EXPECT_P, !have_q && acc_q == '0 && !accovf_q)
	`IDP_ASSERT_SAME(a_sat_value, accovf_q, acc_q == CNT_MAX && have_q)

endmodule

`default_nettype wire

/* hdl/idp_total.sv */
// Result pipeline: capture, constant-weight products, final sum and output register.
// Depends on idp_pkg.
`default_nettype none

module idp_total import idp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_valid,
	input  wire idp_result_t res,
	output logic             take_ok,
	input  wire logic        result_ready,
	output logic             result_valid,
	output logic [31:0]      years,
	output logic [31:0]      months,
	output logic [31:0]      weeks,
	output logic [31:0]      days,
	output logic [31:0]      hours,
	output logic [31:0]      mins,
	output logic [31:0]      secs,
	output logic [31:0]      total_minutes,
	output logic             overflow
);

	typedef struct packed {
		logic [31:0] hours;
		logic [31:0] days;
		logic [31:0] weeks;
		logic [31:0] months;
		logic [31:0] years;
	} idp_prod_t;

	logic        valid_s1, valid_s2, valid_q;
	logic        adv1, adv2, adv_out;
	idp_result_t res_s1, res_s2, res_q;
	idp_prod_t   prod_s2;
	logic [31:0] total_q;

	assign adv_out = !valid_q || result_ready;
	assign adv2    = !valid_s2 || adv_out;
	assign adv1    = !valid_s1 || adv2;
	assign take_ok = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv1)    valid_s1 <= res_valid;
			if (adv2)    valid_s2 <= valid_s1;
			if (adv_out) valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && res_valid) begin
			res_s1 <= res;
		end
		if (adv2 && valid_s1) begin
			res_s2         <= res_s1;
			prod_s2.hours  <= res_s1.cnt[SLOT_HOURS]  * MIN_PER_HOUR;
			prod_s2.days   <= res_s1.cnt[SLOT_DAYS]   * MIN_PER_DAY;
			prod_s2.weeks  <= res_s1.cnt[SLOT_WEEKS]  * MIN_PER_WEEK;
			prod_s2.months <= res_s1.cnt[SLOT_MONTHS] * MIN_PER_MONTH;
			prod_s2.years  <= res_s1.cnt[SLOT_YEARS]  * MIN_PER_YEAR;
		end
		if (adv_out && valid_s2) begin
			res_q   <= res_s2;
			// adder tree, mod 2^32
			total_q <= ((res_s2.cnt[SLOT_MINS] + prod_s2.hours)
			          + (prod_s2.days + prod_s2.weeks))
			          + (prod_s2.months + prod_s2.years);
		end
	end

	assign result_valid  = valid_q;
	assign years         = res_q.cnt[SLOT_YEARS];
	assign months        = res_q.cnt[SLOT_MONTHS];
	assign weeks         = res_q.cnt[SLOT_WEEKS];
	assign days          = res_q.cnt[SLOT_DAYS];
	assign hours         = res_q.cnt[SLOT_HOURS];
	assign mins          = res_q.cnt[SLOT_MINS];
	assign secs          = res_q.cnt[SLOT_SECS];
	assign total_minutes = total_q;
	assign overflow      = res_q.overflow;

endmodule

`default_nettype wire

/* hdl/iso_duration_parser_top.sv */
// Streaming ISO 8601 duration parser, top level.
// Depends on idp_pkg, idp_parser and idp_total.
//
// Usage:
//   Input channel (char_valid/char_ready): one ASCII character per transfer,
//   char_code with last_char set on the final character of the string.
//   Output channel (result_valid/result_ready): one transfer per string,
//   carrying years, months, weeks, days, hours, mins, secs (each saturated at
//   2^COUNT_WIDTH-1, shown as its low 32 bits), total_minutes (mod 2^32)
//   and overflow.
// Throughput: one character per cycle while char_ready is high, back to
//   back, including across string boundaries; the grammar state updates
//   in the same cycle. Result path: the capture stage loads on the edge
//   that takes the last character, then the constant-weight product stage,
//   then the sum stage, which drives result_valid.
// Stall: each of the three result stages holds while result_ready is low
//   and every stage after it is full; char_ready drops only when all three
//   are occupied and the output is not taken. Characters are never dropped.
// Reset: arst_n clears the grammar state, counts and all stage valids; the
//   parse then expects a leading P, and a string without one gives all zeros.
`default_nettype none

module iso_duration_parser_top import idp_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      years,
	output logic [31:0]      months,
	output logic [31:0]      weeks,
	output logic [31:0]      days,
	output logic [31:0]      hours,
	output logic [31:0]      mins,
	output logic [31:0]      secs,
	output logic [31:0]      total_minutes,
	output logic             overflow
);

	logic        take;
	logic        take_ok;
	idp_result_t parsed;

	assign char_ready = take_ok;
	assign take       = char_valid && take_ok;

	idp_parser #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_code),
		.last_char (last_char),
		.result    (parsed)
	);

	// a string's result enters the pipeline on its last character
	idp_total u_total (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (take && last_char),
		.res           (parsed),
		.take_ok       (take_ok),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.years         (years),
		.months        (months),
		.weeks         (weeks),
		.days          (days),
		.hours         (hours),
		.mins          (mins),
		.secs          (secs),
		.total_minutes (total_minutes),
		.overflow      (overflow)
	);

endmodule

`default_nettype wire

/* bench/iso_duration_parser_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for iso_duration_parser_top: directed strings, then random duration strings.
// Depends on idp_pkg and the parser RTL; carries its own model of the grammar and the counts.

module iso_duration_parser_top_tb;
	import idp_pkg::*;

	// Expected result of one string: seven counts, weighted total, saturation flag.
	typedef struct packed {
		logic [NUM_FIELDS-1:0][31:0] cnt;
		logic [31:0]                 total;
		logic                        ovf;
	} duration_t;

	localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        char_valid;
	logic        char_ready;
	logic [7:0]  char_code;
	logic        last_char;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] years, months, weeks, days, hours, mins, secs, total_minutes;
	logic        overflow;

	iso_duration_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.char_code     (char_code),
		.last_char     (last_char),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.years         (years),
		.months        (months),
		.weeks         (weeks),
		.days          (days),
		.hours         (hours),
		.mins          (mins),
		.secs          (secs),
		.total_minutes (total_minutes),
		.overflow      (overflow)
	);

	// ---------------------------------------------------------------
	// Parser model state (mirrors the grammar walker inside the block)
	// ---------------------------------------------------------------
	idp_phase_t  parse_phase;
	bit          halted;
	logic [63:0] run_value;     // digit run being collected, clamped at COUNT_MAX
	bit          run_present;
	bit          run_sat;
	logic [31:0] counts [NUM_FIELDS];
	bit          ovf_seen;

	duration_t pending_durations [$];   // one entry per string still in flight
	int        mismatches = 0;
	int        live_chars = 0;          // characters that reached the grammar (not ignored)

	// idle control: gaps_on for the sender, stalls_on for the receiver
	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;

	// string being sent, and what to expect for it
	logic [7:0] msg [$];
	bit         msg_typed;
	duration_t  msg_want;

	// directed table
	string     row_text  [$];
	int        row_nul   [$];
	bit        row_typed [$];
	duration_t row_want  [$];

	logic [7:0] date_marks [4]     = '{CH_Y, CH_M, CH_W, CH_D};
	logic [7:0] time_marks [3]     = '{CH_H, CH_M, CH_S};
	logic [7:0] grammar_chars [10] = '{CH_P, CH_T, CH_Y, CH_M, CH_W, CH_D, CH_H, CH_S,
		CH_0, CH_9};
	string      field_name [NUM_FIELDS] = '{"years", "months", "weeks", "days", "hours",
		"mins", "secs"};

	// ordinal of a phase, so the "this designator or a later one" rules read as compares
	function automatic int phase_rank(idp_phase_t ph);
		case (ph)
			PH_EXPECT_P:  return 0;
			PH_DATE_Y:    return 1;
			PH_DATE_M:    return 2;
			PH_DATE_W:    return 3;
			PH_DATE_D:    return 4;
			PH_DATE_DONE: return 5;
			PH_TIME_H:    return 6;
			PH_TIME_M:    return 7;
			PH_TIME_S:    return 8;
			default:      return 9;
		endcase
	endfunction

	function automatic void drop_run();
		run_value   = '0;
		run_present = 1'b0;
		run_sat     = 1'b0;
	endfunction

	function automatic void clear_parse();
		parse_phase = PH_EXPECT_P;
		halted      = 1'b0;
		ovf_seen    = 1'b0;
		drop_run();
		for (int f = 0; f < NUM_FIELDS; f++)
			counts[f] = '0;
	endfunction

	// grammar break: freeze counts, forget any open digit run
	function automatic void halt_parse();
		halted = 1'b1;
		drop_run();
	endfunction

	// designator closes the digit run into its slot
	function automatic void take_count(input logic [2:0] slot, input idp_phase_t next_ph);
		counts[slot] = run_value[31:0];
		if (run_sat)
			ovf_seen = 1'b1;
		drop_run();
		parse_phase = next_ph;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		int          rk;
		logic [63:0] digit;
		rk    = phase_rank(parse_phase);
		digit = {56'd0, c - CH_0};
		if (halted) begin
			// ignored until the string ends
		end else if (parse_phase == PH_EXPECT_P) begin
			if (c == CH_P)
				parse_phase = PH_DATE_Y;
			else
				halt_parse();
		end else if (c >= CH_0 && c <= CH_9) begin
			// digits only where a designator can still follow
			if (!((rk >= 1 && rk <= 4) || (rk >= 6 && rk <= 8))) begin
				halt_parse();
			end else begin
				if (run_value > (COUNT_MAX - digit) / 10) begin
					run_value = COUNT_MAX;
					run_sat   = 1'b1;
				end else begin
					run_value = run_value * 10 + digit;
				end
				run_present = 1'b1;
			end
		end else if (c == CH_T) begin
			if (!run_present && rk >= 1 && rk <= 5)
				parse_phase = PH_TIME_H;
			else
				halt_parse();
		end else if (!run_present) begin
			halt_parse();
		end else if (rk <= 4) begin
			if (c == CH_Y && rk <= 1)
				take_count(SLOT_YEARS, PH_DATE_M);
			else if (c == CH_M && rk <= 2)
				take_count(SLOT_MONTHS, PH_DATE_W);
			else if (c == CH_W && rk <= 3)
				take_count(SLOT_WEEKS, PH_DATE_D);
			else if (c == CH_D)
				take_count(SLOT_DAYS, PH_DATE_DONE);
			else
				halt_parse();
		end else if (rk >= 6 && rk <= 8) begin
			if (c == CH_H && rk <= 6)
				take_count(SLOT_HOURS, PH_TIME_M);
			else if (c == CH_M && rk <= 7)
				take_count(SLOT_MINS, PH_TIME_S);
			else if (c == CH_S)
				take_count(SLOT_SECS, PH_ALL_DONE);
			else
				halt_parse();
		end else begin
			halt_parse();
		end
	endfunction

	// One accepted character. On the last one, queue the expected result and restart.
	// A typed row replaces the model's answer with the hand-written one.
	function automatic void step_parser(input logic [7:0] c, input logic last,
			input bit typed, input duration_t typed_want);
		duration_t want;
		if (!halted)
			live_chars++;
		parse_char(c);
		if (last) begin
			for (int f = 0; f < NUM_FIELDS; f++)
				want.cnt[f] = counts[f];
			// 32-bit products and sum wrap, same as the block
			want.total = counts[SLOT_MINS]
				+ counts[SLOT_HOURS]  * MIN_PER_HOUR
				+ counts[SLOT_DAYS]   * MIN_PER_DAY
				+ counts[SLOT_WEEKS]  * MIN_PER_WEEK
				+ counts[SLOT_MONTHS] * MIN_PER_MONTH
				+ counts[SLOT_YEARS]  * MIN_PER_YEAR;
			want.ovf = ovf_seen;
			pending_durations.push_back(typed ? typed_want : want);
			clear_parse();
		end
	endfunction

	task automatic add_row(input string text, input bit typed, input duration_t want,
			input int nul_at);
		row_text.push_back(text);
		row_typed.push_back(typed);
		row_want.push_back(want);
		row_nul.push_back(nul_at);
	endtask

	// Push msg one character per transfer. Inputs change on the falling edge;
	// the handshake is sampled on the rising edge.
	task automatic send_msg();
		for (int i = 0; i < msg.size(); i++) begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				char_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			char_valid <= 1'b1;
			char_code  <= msg[i];
			last_char  <= (i == msg.size() - 1);
			do @(posedge clk); while (!char_ready);
			step_parser(msg[i], i == msg.size() - 1, msg_typed, msg_want);
		end
	endtask

	// drop valid before the next rising edge so the last transfer is not repeated
	task automatic wait_drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (pending_durations.size() != 0)
			@(posedge clk);
	endtask

	// append a digit run: mostly short, some long enough to saturate
	task automatic put_number();
		string s;
		case ($urandom_range(0, 9))
			6, 7: s = $sformatf("%0d", $urandom_range(0, 99999));
			8: begin
				if ($urandom_range(0, 1))
					s = $sformatf("%0d", 64'd4294967294 + $urandom_range(0, 2));
				else
					s = $sformatf("%0d%0d", $urandom(), $urandom_range(0, 99));
			end
			9: s = $sformatf("00%0d", $urandom_range(0, 9));
			default: s = $sformatf("%0d", $urandom_range(0, 99));
		endcase
		for (int k = 0; k < s.len(); k++)
			msg.push_back(s[k]);
	endtask

	// Break an otherwise well-formed string in one of several ways.
	task automatic add_noise();
		int pos;
		pos = $urandom_range(0, msg.size() - 1);
		case ($urandom_range(0, 4))
			0: msg.insert($urandom_range(0, msg.size()), 8'($urandom_range(0, 255)));
			1: msg[pos] = grammar_chars[$urandom_range(0, 9)];
			2: if (msg.size() > 1) void'(msg.pop_back());   // often leaves a run open
			3: msg[0] = 8'($urandom_range(0, 255));          // usually a leading non-P
			default: begin
				msg.delete();
				repeat ($urandom_range(1, 6))
					msg.push_back(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// P, optional date pairs in order, optional T with time pairs in order.
	task automatic build_random_msg();
		msg.delete();
		msg.push_back(CH_P);
		foreach (date_marks[k]) begin
			if ($urandom_range(0, 1)) begin
				put_number();
				msg.push_back(date_marks[k]);
			end
		end
		if ($urandom_range(0, 1)) begin
			msg.push_back(CH_T);
			foreach (time_marks[k]) begin
				if ($urandom_range(0, 1)) begin
					put_number();
					msg.push_back(time_marks[k]);
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			add_noise();
	endtask

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Result side: random ready bursts, then compare every transfer
	// ---------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left   = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 13);
			result_ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		duration_t want;
		duration_t got;
		if (arst_n && result_valid && result_ready) begin
			got.cnt[SLOT_YEARS]  = years;
			got.cnt[SLOT_MONTHS] = months;
			got.cnt[SLOT_WEEKS]  = weeks;
			got.cnt[SLOT_DAYS]   = days;
			got.cnt[SLOT_HOURS]  = hours;
			got.cnt[SLOT_MINS]   = mins;
			got.cnt[SLOT_SECS]   = secs;
			got.total            = total_minutes;
			got.ovf              = overflow;
			if (pending_durations.size() == 0) begin
				$display("%0t: result transfer with nothing expected (total_minutes %0d)",
					$time, total_minutes);
				mismatches++;
			end else begin
				want = pending_durations.pop_front();
				for (int f = 0; f < NUM_FIELDS; f++) begin
					if (got.cnt[f] !== want.cnt[f]) begin
						$display("%0t: %s expected %0d got %0d", $time, field_name[f],
							want.cnt[f], got.cnt[f]);
						mismatches++;
					end
				end
				if (got.total !== want.total) begin
					$display("%0t: total_minutes expected %0d got %0d", $time,
						want.total, got.total);
					mismatches++;
				end
				if (got.ovf !== want.ovf) begin
					$display("%0t: overflow expected %0b got %0b", $time, want.ovf, got.ovf);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		duration_t zero_want;
		duration_t sat_want;
		int        random_start;
		int        strings_sent;
		bit        calm;

		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_code  = '0;
		last_char  = 1'b0;
		clear_parse();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		zero_want = '0;
		// one run just past 2^32-1: clamps to all ones and raises the flag;
		// total is (2^32-1) * 525960 mod 2^32
		sat_want                  = '0;
		sat_want.cnt[SLOT_YEARS]  = '1;
		sat_want.total            = 32'hFFF7_F978;
		sat_want.ovf              = 1'b1;

		// text, typed?, expected, position driven as NUL (-1: none)
		add_row("P",                1, zero_want, -1);  // bare P right after reset
		add_row("?",                1, zero_want,  0);  // NUL as leading char: no P
		add_row("P\377",            1, zero_want, -1);  // top code after P stops the parse
		add_row("P1Y2M3W4DT5H6M7S", 0, zero_want, -1);  // every designator in order
		add_row("P4294967296Y",     1, sat_want,  -1);  // saturated count accepted
		add_row("PT4294967295S",    0, zero_want, -1);  // exactly the max, no flag
		add_row("P1M1Y",            0, zero_want, -1);  // out-of-order designator
		add_row("PT12",             1, zero_want, -1);  // unfinished run dropped
		add_row("P2T",              1, zero_want, -1);  // T right after digits
		add_row("P1D2",             0, zero_want, -1);  // digits after D, no T
		add_row("PT2HT",            0, zero_want, -1);  // second T

		foreach (row_text[r]) begin
			msg.delete();
			for (int k = 0; k < row_text[r].len(); k++)
				msg.push_back(k == row_nul[r] ? 8'h00 : row_text[r][k]);
			msg_typed = row_typed[r];
			msg_want  = row_want[r];
			send_msg();
		end

		// hold the sender until the pipe is empty, then go random
		wait_drain();

		msg_typed    = 1'b0;
		msg_want     = '0;
		random_start = live_chars;
		strings_sent = 0;
		calm         = 1'b0;
		while (live_chars - random_start < 500) begin
			if (!calm && strings_sent % 6 == 0) begin
				gaps_on   = ($urandom_range(0, 2) != 0);
				stalls_on = ($urandom_range(0, 2) != 0);
			end
			// last stretch runs flat out on both sides
			if (live_chars - random_start >= 420) begin
				calm      = 1'b1;
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			if (strings_sent == 20)
				wait_drain();
			build_random_msg();
			send_msg();
			strings_sent++;
		end

		@(negedge clk);
		char_valid <= 1'b0;
		wait_drain();
		// run on past the 3-stage pipeline to catch stray results
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("iso_duration_parser_top_tb: PASS");
		else
			$display("iso_duration_parser_top_tb: FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("iso_duration_parser_top_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/idp_pkg.sv
hdl/idp_parser.sv
hdl/idp_total.sv
hdl/iso_duration_parser_top.sv
bench/iso_duration_parser_top_tb.sv
